// ===== design/tcbpa_pkg.sv =====
// Shared types and constants for the two-class block pool allocator.
package tcbpa_pkg;

	// Default number of blocks in each pool.
	localparam int unsigned BLOCKS_PER_POOL_DEF = 256;

	// Block geometry of the two pools.
	localparam int unsigned SMALL_BYTES = 16;
	localparam int unsigned LARGE_BYTES = 64;
	localparam int unsigned SMALL_SHIFT = 4;
	localparam int unsigned LARGE_SHIFT = 6;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Pool class codes.
	localparam logic CLS_SMALL = 1'b0;
	localparam logic CLS_LARGE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_SMALL_BASE = 1'b0;
	localparam logic REG_LARGE_BASE = 1'b1;

	// Result status codes.
	localparam logic [2:0] STS_ALLOCATED   = 3'd0;
	localparam logic [2:0] STS_BAD_SIZE    = 3'd1;
	localparam logic [2:0] STS_EMPTY       = 3'd2;
	localparam logic [2:0] STS_FREED       = 3'd3;
	localparam logic [2:0] STS_NOT_IN_POOL = 3'd4;
	localparam logic [2:0] STS_NULL        = 3'd5;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORK
	} state_t;

	// Outcome of the free address decode.
	typedef struct packed {
		logic hit;
		logic cls;
	} free_sel_t;

endpackage

// ===== design/tcbpa_next_mem.sv =====
// Next-index memory of one pool, one port, synchronous read.
module tcbpa_next_mem #(
	parameter int unsigned DEPTH = tcbpa_pkg::BLOCKS_PER_POOL_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     addr,
	input  logic [$clog2(DEPTH+1)-1:0]   wdata,
	output logic [$clog2(DEPTH+1)-1:0]   rdata
);
	localparam int unsigned DW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tcbpa_free_decode.sv =====
// Maps a freed address to its pool and block index.
module tcbpa_free_decode #(
	parameter int unsigned BLOCKS_PER_POOL = tcbpa_pkg::BLOCKS_PER_POOL_DEF
) (
	input  logic [31:0]                          addr,
	input  logic [31:0]                          small_base,
	input  logic [32:0]                          small_last,
	input  logic [31:0]                          large_base,
	input  logic [32:0]                          large_last,
	output tcbpa_pkg::free_sel_t                 sel,
	output logic [$clog2(BLOCKS_PER_POOL)-1:0]   idx
);
	import tcbpa_pkg::*;

	localparam int unsigned AW = $clog2(BLOCKS_PER_POOL);

	logic        in_small;
	logic        in_large;
	logic [31:0] off_small;
	logic [31:0] off_large;
	logic [31:0] idx_small;
	logic [31:0] idx_large;

	// Ranges are compared on 33 bits so that a pool running past the top
	// of the address space does not wrap.
	assign in_small  = (addr >= small_base) && ({1'b0, addr} <= small_last);
	assign in_large  = (addr >= large_base) && ({1'b0, addr} <= large_last);
	assign off_small = addr - small_base;
	assign off_large = addr - large_base;
	assign idx_small = off_small >> SMALL_SHIFT;
	assign idx_large = off_large >> LARGE_SHIFT;

	always_comb begin
		sel.hit = 1'b0;
		sel.cls = CLS_SMALL;
		idx     = idx_small[AW-1:0];
		if (in_small) begin
			sel.hit = (idx_small < 32'(BLOCKS_PER_POOL));
		end else if (in_large) begin
			sel.hit = (idx_large < 32'(BLOCKS_PER_POOL));
			sel.cls = CLS_LARGE;
			idx     = idx_large[AW-1:0];
		end
	end

endmodule

// ===== design/two_class_block_pool_allocator.sv =====
// Top level of the two-class block pool allocator.
// done and the result are registered at the end of the work cycle that follows an accepted word.
// A new word is taken only in the idle state, once the last one is finished; the next-index memory read sets the pace.
// After reset the block sweeps every entry of both next-index memories,
// holding busy high; configuration writes are taken during that sweep.
// Results cannot be stalled: done marks a word for exactly one cycle.
module two_class_block_pool_allocator #(
	parameter int unsigned BLOCKS_PER_POOL = tcbpa_pkg::BLOCKS_PER_POOL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [15:0] request_size,
	input  logic [31:0] block_address,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] granted_address,
	output logic        pool_class,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	import tcbpa_pkg::*;

	localparam int unsigned AW = $clog2(BLOCKS_PER_POOL);
	localparam int unsigned IW = $clog2(BLOCKS_PER_POOL + 1);
	// Offset from a pool base to its last block.
	localparam logic [32:0] SMALL_SPAN = 33'((BLOCKS_PER_POOL - 1) * SMALL_BYTES);
	localparam logic [32:0] LARGE_SPAN = 33'((BLOCKS_PER_POOL - 1) * LARGE_BYTES);
	// The index value that marks an empty list.
	localparam logic [IW-1:0] NULL_IDX = IW'(BLOCKS_PER_POOL);

	state_t state_q, state_d;

	// Configuration. The last address of each pool is worked out when its
	// base is written, which keeps the adder out of the free decode path.
	logic [31:0] small_base_q, large_base_q;
	logic [32:0] small_last_q, large_last_q;

	// List heads and the clearing sweep counter.
	logic [IW-1:0] small_head_q, large_head_q;
	logic [AW-1:0] clr_q;

	// Request held for the work cycle.
	logic        cmd_s1;
	logic [15:0] size_s1;
	logic [31:0] addr_s1;

	// Result register.
	logic        done_q;
	logic [2:0]  status_q;
	logic [31:0] granted_q;
	logic        class_q;

	// Memory ports.
	logic          sm_en, sm_we, lg_en, lg_we;
	logic [AW-1:0] sm_addr, lg_addr;
	logic [IW-1:0] sm_wdata, lg_wdata;
	logic [IW-1:0] sm_rdata, lg_rdata;

	free_sel_t     fsel;
	logic [AW-1:0] fidx;

	// Decode of the incoming word, used to issue the memory read.
	logic          in_cls;
	logic          accept;

	// Work cycle decode.
	logic          size_ok;
	logic          work_cls;
	logic [IW-1:0] work_head;
	logic          work_empty;
	logic [31:0]   work_base;
	logic [31:0]   work_granted;
	logic          clr_last;

	assign accept   = start && !busy;
	assign in_cls   = (request_size > 16'(SMALL_BYTES)) ? CLS_LARGE : CLS_SMALL;
	assign clr_last = (clr_q == AW'(BLOCKS_PER_POOL - 1));

	assign size_ok    = (size_s1 != 16'd0) && (size_s1 <= 16'(LARGE_BYTES));
	assign work_cls   = (size_s1 > 16'(SMALL_BYTES)) ? CLS_LARGE : CLS_SMALL;
	assign work_head  = (work_cls == CLS_LARGE) ? large_head_q : small_head_q;
	assign work_empty = (work_head >= NULL_IDX);
	assign work_base  = (work_cls == CLS_LARGE) ? large_base_q : small_base_q;
	assign work_granted = (work_cls == CLS_LARGE)
		? work_base + (32'(work_head) << LARGE_SHIFT)
		: work_base + (32'(work_head) << SMALL_SHIFT);

	tcbpa_free_decode #(
		.BLOCKS_PER_POOL(BLOCKS_PER_POOL)
	) u_free_decode (
		.addr       (addr_s1),
		.small_base (small_base_q),
		.small_last (small_last_q),
		.large_base (large_base_q),
		.large_last (large_last_q),
		.sel        (fsel),
		.idx        (fidx)
	);

	tcbpa_next_mem #(
		.DEPTH(BLOCKS_PER_POOL)
	) u_small_mem (
		.clk   (clk),
		.en    (sm_en),
		.we    (sm_we),
		.addr  (sm_addr),
		.wdata (sm_wdata),
		.rdata (sm_rdata)
	);

	tcbpa_next_mem #(
		.DEPTH(BLOCKS_PER_POOL)
	) u_large_mem (
		.clk   (clk),
		.en    (lg_en),
		.we    (lg_we),
		.addr  (lg_addr),
		.wdata (lg_wdata),
		.rdata (lg_rdata)
	);

	// Next state: sweep once after reset, then alternate between taking a
	// word and finishing it.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the controller: busy and the memory ports.
	always_comb begin
		busy     = 1'b1;
		sm_en    = 1'b0;
		sm_we    = 1'b0;
		sm_addr  = small_head_q[AW-1:0];
		sm_wdata = small_head_q;
		lg_en    = 1'b0;
		lg_we    = 1'b0;
		lg_addr  = large_head_q[AW-1:0];
		lg_wdata = large_head_q;
		case (state_q)
			ST_CLEAR: begin
				// Chain entry i to i+1; the last entry gets the null index.
				sm_en    = 1'b1;
				sm_we    = 1'b1;
				sm_addr  = clr_q;
				sm_wdata = IW'(clr_q) + IW'(1);
				lg_en    = 1'b1;
				lg_we    = 1'b1;
				lg_addr  = clr_q;
				lg_wdata = IW'(clr_q) + IW'(1);
			end
			ST_IDLE: begin
				busy = 1'b0;
				// Read the link of the head so it is ready in the work cycle.
				// An empty list is not read.
				if (start && (command == CMD_ALLOC)) begin
					sm_en = (in_cls == CLS_SMALL) && (small_head_q < NULL_IDX);
					lg_en = (in_cls == CLS_LARGE) && (large_head_q < NULL_IDX);
				end
			end
			ST_WORK: begin
				// A free links the block to the old head.
				if ((cmd_s1 == CMD_FREE) && (addr_s1 != 32'd0) && fsel.hit) begin
					if (fsel.cls == CLS_LARGE) begin
						lg_en   = 1'b1;
						lg_we   = 1'b1;
						lg_addr = fidx;
					end else begin
						sm_en   = 1'b1;
						sm_we   = 1'b1;
						sm_addr = fidx;
					end
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			small_base_q <= '0;
			large_base_q <= '0;
			small_last_q <= SMALL_SPAN;
			large_last_q <= LARGE_SPAN;
			small_head_q <= '0;
			large_head_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WORK);

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end

			if (cfg_we) begin
				if (cfg_index == REG_SMALL_BASE) begin
					small_base_q <= cfg_wdata;
					small_last_q <= {1'b0, cfg_wdata} + SMALL_SPAN;
				end else begin
					large_base_q <= cfg_wdata;
					large_last_q <= {1'b0, cfg_wdata} + LARGE_SPAN;
				end
			end

			// Head updates happen only at the end of the work cycle.
			if (state_q == ST_WORK) begin
				if (cmd_s1 == CMD_ALLOC) begin
					if (size_ok && !work_empty) begin
						if (work_cls == CLS_LARGE) begin
							large_head_q <= lg_rdata;
						end else begin
							small_head_q <= sm_rdata;
						end
					end
				end else if ((addr_s1 != 32'd0) && fsel.hit) begin
					if (fsel.cls == CLS_LARGE) begin
						large_head_q <= IW'(fidx);
					end else begin
						small_head_q <= IW'(fidx);
					end
				end
			end
		end
	end

	// Request capture and result register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			size_s1 <= request_size;
			addr_s1 <= block_address;
		end
		if (state_q == ST_WORK) begin
			granted_q <= 32'd0;
			class_q   <= CLS_SMALL;
			if (cmd_s1 == CMD_ALLOC) begin
				if (!size_ok) begin
					status_q <= STS_BAD_SIZE;
				end else if (work_empty) begin
					status_q <= STS_EMPTY;
					class_q  <= work_cls;
				end else begin
					status_q  <= STS_ALLOCATED;
					granted_q <= work_granted;
					class_q   <= work_cls;
				end
			end else if (addr_s1 == 32'd0) begin
				status_q <= STS_NULL;
			end else if (!fsel.hit) begin
				status_q <= STS_NOT_IN_POOL;
			end else begin
				status_q <= STS_FREED;
				class_q  <= fsel.cls;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign pool_class      = class_q;

	// A result only follows a work cycle.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_WORK))
		else $error("result strobe without a preceding work cycle");

	// No word is taken while the memories are being swept.
	a_busy_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy)
		else $error("ready during the clearing sweep");

	// Only a granted block carries an address.
	a_granted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != STS_ALLOCATED)) |-> (granted_q == 32'd0))
		else $error("address returned without an allocation");

	// List heads hold a block index or the null mark, never more.
	a_heads_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(small_head_q <= NULL_IDX) && (large_head_q <= NULL_IDX))
		else $error("list head beyond the null index");

	// The memories are never written while a read result is still needed.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(sm_we || lg_we))
		else $error("memory write outside sweep or work cycle");

endmodule
